### sv/cpfv_pkg.sv
// Shared types, constants and helper functions for the CPF/CNPJ check-digit validator.
package cpfv_pkg;

  // Expected digit counts
  localparam logic [3:0] CPF_LEN   = 4'd11;
  localparam logic [3:0] CNPJ_LEN  = 4'd14;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  // Mode register encoding
  localparam logic MODE_CPF  = 1'b0;
  localparam logic MODE_CNPJ = 1'b1;

  // Which running sum a weight belongs to
  localparam logic SUM_FIRST  = 1'b0;
  localparam logic SUM_SECOND = 1'b1;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Verdict codes
  typedef enum logic [1:0] {
    FAIL_NONE  = 2'd0,
    FAIL_COUNT = 2'd1,
    FAIL_SAME  = 2'd2,
    FAIL_CHECK = 2'd3
  } fail_code_t;

  // One classified text byte
  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       last;
  } cpfv_word_t;

  // Weight of digit position pos in the first or second sum
  function automatic logic [3:0] digit_weight(input logic mode, input logic which,
                                              input logic [3:0] pos);
    logic [4:0] p;
    logic [4:0] top;
    logic [4:0] head;
    logic [4:0] span;
    logic [4:0] w;
    p    = {1'b0, pos};
    top  = 5'd10 + {4'd0, which};
    head = 5'd5 + {4'd0, which};
    span = 5'd12 + {4'd0, which};
    if (mode == MODE_CPF) begin
      w = (p < top - 5'd1) ? (top - p) : 5'd0;
    end else begin
      if (p >= span) w = 5'd0;
      else if (p < head - 5'd1) w = head - p;
      else w = span + 5'd1 - p;
    end
    return w[3:0];
  endfunction

  // x mod 11 for x below 128: reciprocal multiply, exact over this range
  function automatic logic [3:0] mod11(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 15'(x) * 15'd187;
    q    = prod[14:11];
    r    = x - 7'(7'(q) * 7'd11);
    return r[3:0];
  endfunction

  // Check digit expected from a residue mod 11
  function automatic logic [3:0] check_digit(input logic [3:0] r);
    return (r < 4'd2) ? 4'd0 : (4'd11 - r);
  endfunction

endpackage

### sv/cpfv_front.sv
// Front end: classifies text bytes and buffers them in a short queue for the back end.
module cpfv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char_byte,
  input  logic                in_last_char,
  output logic                pop_valid,
  input  logic                pop_ready,
  output cpfv_pkg::cpfv_word_t pop_word
);
  import cpfv_pkg::*;

  cpfv_word_t             q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]     fill_r, fill_nxt;
  cpfv_word_t             word_in;
  logic                   push, pop;

  // Classify the incoming byte
  always_comb begin
    word_in.is_digit = (in_char_byte >= 8'h30) && (in_char_byte <= 8'h39);
    word_in.digit    = 4'(in_char_byte - 8'h30);
    word_in.last     = in_last_char;
  end

  assign in_ready  = (fill_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_word  = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = pop_valid && pop_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) fill_nxt = fill_r + 1'b1;
    else if (pop && !push) fill_nxt = fill_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= word_in;
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue fill above depth");
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("queue fill did not follow a push");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == Q_CNT_W'(Q_DEPTH)) |-> !in_ready)
    else $error("input ready while queue full");
`endif

endmodule

### sv/cpfv_back.sv
// Back end: accumulates digit count and mod-11 residues, forms the verdict word.
module cpfv_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mode,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  cpfv_pkg::cpfv_word_t pop_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_valid,
  output logic [1:0]           out_fail_code
);
  import cpfv_pkg::*;

  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  res1_r, res1_nxt;
  logic [3:0]  res2_r, res2_nxt;
  logic [3:0]  first_r, first_nxt;
  logic        same_r, same_nxt;
  logic [3:0]  prev_r, prev_nxt;
  logic [3:0]  latest_r, latest_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_is_valid_r, out_is_valid_nxt;
  fail_code_t  out_code_r, out_code_nxt;

  logic        out_free, take;
  logic [7:0]  prod1, prod2;
  logic [3:0]  need;
  fail_code_t  code;

  assign out_free  = !out_valid_r || out_ready;
  assign pop_ready = !pop_word.last || out_free;
  assign take      = pop_valid && pop_ready;

  // Weighted products for this digit position
  assign prod1 = {4'd0, pop_word.digit} * {4'd0, digit_weight(mode, SUM_FIRST, cnt_r)};
  assign prod2 = {4'd0, pop_word.digit} * {4'd0, digit_weight(mode, SUM_SECOND, cnt_r)};

  // Running state after this word
  always_comb begin
    cnt_nxt    = cnt_r;
    res1_nxt   = res1_r;
    res2_nxt   = res2_r;
    first_nxt  = first_r;
    same_nxt   = same_r;
    prev_nxt   = prev_r;
    latest_nxt = latest_r;
    if (pop_word.is_digit) begin
      res1_nxt = mod11(7'(res1_r) + prod1[6:0]);
      res2_nxt = mod11(7'(res2_r) + prod2[6:0]);
      if (cnt_r == 4'd0) first_nxt = pop_word.digit;
      else if (pop_word.digit != first_r) same_nxt = 1'b0;
      prev_nxt   = latest_r;
      latest_nxt = pop_word.digit;
      if (cnt_r != COUNT_MAX) cnt_nxt = cnt_r + 4'd1;
    end
  end

  // Verdict from the updated state
  always_comb begin
    need = (mode == MODE_CPF) ? CPF_LEN : CNPJ_LEN;
    priority if (cnt_nxt != need) code = FAIL_COUNT;
    else if (same_nxt) code = FAIL_SAME;
    else if (prev_nxt != check_digit(res1_nxt) || latest_nxt != check_digit(res2_nxt))
      code = FAIL_CHECK;
    else code = FAIL_NONE;
  end

  // Output register
  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_is_valid_nxt = out_is_valid_r;
    out_code_nxt     = out_code_r;
    if (out_free) begin
      out_valid_nxt = take && pop_word.last;
      if (take && pop_word.last) begin
        out_is_valid_nxt = (code == FAIL_NONE);
        out_code_nxt     = code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      res1_r      <= '0;
      res2_r      <= '0;
      first_r     <= '0;
      same_r      <= 1'b1;
      prev_r      <= '0;
      latest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        if (pop_word.last) begin
          cnt_r    <= '0;
          res1_r   <= '0;
          res2_r   <= '0;
          first_r  <= '0;
          same_r   <= 1'b1;
          prev_r   <= '0;
          latest_r <= '0;
        end else begin
          cnt_r    <= cnt_nxt;
          res1_r   <= res1_nxt;
          res2_r   <= res2_nxt;
          first_r  <= first_nxt;
          same_r   <= same_nxt;
          prev_r   <= prev_nxt;
          latest_r <= latest_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_is_valid_r <= out_is_valid_nxt;
    out_code_r     <= out_code_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_is_valid  = out_is_valid_r;
  assign out_fail_code = out_code_r;

`ifndef ASSERT_OFF
  a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_is_valid_r == (out_code_r == FAIL_NONE)))
    else $error("is_valid disagrees with fail code");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && pop_word.last) |=> (cnt_r == 4'd0 && same_r && res1_r == 4'd0))
    else $error("state not cleared after last word");
  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res1_r < 4'd11) && (res2_r < 4'd11))
    else $error("residue out of mod-11 range");
  a_no_verdict_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(take && pop_word.last))
    else $error("verdict taken while output register busy");
`endif

endmodule

### sv/cpf_cnpj_check_digit_validator_top.sv
// CPF/CNPJ mod-11 check-digit validator: one text byte per word in, one verdict word per text.
// Takes one byte per clock while the queue has room. Each byte is classified
// in the front end and written into a 2-word queue; the back end takes one
// word per cycle from the queue when not stalled, updates the digit count and
// two mod-11 residues, and on the word marked last writes the verdict into an
// output register; the last byte of a text passes through the queue, then its
// verdict is held in the output register. The back end stalls only when a last word
// meets an output register still holding an untaken verdict; the queue
// absorbs that stall. cfg_wdata selects CPF (0, 11 digits) or CNPJ (1, 14
// digits); write it only between texts.
module cpf_cnpj_check_digit_validator_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_valid,
  output logic [1:0] out_fail_code
);
  import cpfv_pkg::*;

  logic       id_mode_r;
  logic       pop_valid, pop_ready;
  cpfv_word_t pop_word;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_mode_r <= MODE_CPF;
    end else if (cfg_we) begin
      id_mode_r <= cfg_wdata;
    end
  end

  cpfv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .in_last_char (in_last_char),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_word     (pop_word)
  );

  cpfv_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (id_mode_r),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_word      (pop_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_is_valid  (out_is_valid),
    .out_fail_code (out_fail_code)
  );

endmodule

### bench/testbench.sv
// Self-checking bench for the CPF/CNPJ check-digit validator: directed table, then random texts.
`timescale 1ns / 1ps

module testbench;
  import cpfv_pkg::*;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam int PHASE_WORDS = 380;
  localparam int PHASES      = 5;
  localparam int DRAIN_SLACK = 6;
  localparam int HOLD_CYCLES = 250;
  localparam int IDLE_PCT    = 37;
  localparam int LIMIT_NS    = 8_000_000;

  typedef struct {
    logic       ok;
    fail_code_t code;
  } verdict_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
    logic       typed;
    fail_code_t code;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_byte = 8'h00;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_is_valid;
  logic [1:0] out_fail_code;

  cpf_cnpj_check_digit_validator_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_valid (out_is_valid),
    .out_fail_code(out_fail_code)
  );

  always #10 clk = ~clk;

  // Verdicts owed by the block, oldest first
  verdict_t   pending_verdicts[$];
  stim_row_t  directed_rows[$];
  logic [7:0] text_q[$];
  int         mismatches = 0;
  int         words_sent = 0;
  int         hold_requests = 0;
  bit         calm = 1'b0;

  // Shadow copy of the text state
  logic       mode_now = MODE_CPF;
  logic [3:0] n_digits = 4'd0;
  logic [9:0] sum_first = 10'd0;
  logic [9:0] sum_second = 10'd0;
  logic [3:0] lead_digit = 4'd0;
  logic       all_same = 1'b1;
  logic [3:0] prev_digit = 4'd0;
  logic [3:0] tail_digit = 4'd0;

  // CPF: 10..2 / 11..2; CNPJ: 5..2,9..2 / 6..2,9..2; zero past the weighted range
  function automatic int unsigned position_weight(input logic mode, input logic second,
                                                  input logic [3:0] pos);
    int unsigned p;
    int unsigned bump;
    p    = pos;
    bump = (second == SUM_SECOND) ? 1 : 0;
    if (mode == MODE_CPF) return (p < 9 + bump) ? (10 + bump - p) : 0;
    if (p < 4 + bump) return 5 + bump - p;
    if (p < 12 + bump) return 13 + bump - p;
    return 0;
  endfunction

  function automatic logic [3:0] check_of(input logic [9:0] s);
    int unsigned r;
    r = s % 11;
    return (r < 2) ? 4'd0 : 4'(11 - r);
  endfunction

  // Advance the shadow state by one byte; returns 1 when a verdict is due
  function automatic bit predict_byte(input logic [7:0] ch, input logic lst,
                                      output verdict_t v);
    logic [3:0] d;
    logic [3:0] need;
    v.ok   = 1'b0;
    v.code = FAIL_NONE;
    if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
      d          = 4'(ch - ASCII_ZERO);
      sum_first  = 10'(sum_first + d * position_weight(mode_now, SUM_FIRST, n_digits));
      sum_second = 10'(sum_second + d * position_weight(mode_now, SUM_SECOND, n_digits));
      if (n_digits == 4'd0) lead_digit = d;
      else if (d != lead_digit) all_same = 1'b0;
      prev_digit = tail_digit;
      tail_digit = d;
      if (n_digits != COUNT_MAX) n_digits = n_digits + 4'd1;
    end
    if (!lst) return 1'b0;
    need = (mode_now == MODE_CPF) ? CPF_LEN : CNPJ_LEN;
    if (n_digits != need) v.code = FAIL_COUNT;
    else if (all_same) v.code = FAIL_SAME;
    else if (prev_digit != check_of(sum_first) || tail_digit != check_of(sum_second))
      v.code = FAIL_CHECK;
    else v.code = FAIL_NONE;
    v.ok       = (v.code == FAIL_NONE);
    n_digits   = 4'd0;
    sum_first  = 10'd0;
    sum_second = 10'd0;
    lead_digit = 4'd0;
    all_same   = 1'b1;
    prev_digit = 4'd0;
    tail_digit = 4'd0;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [7:0] ch, input logic lst, input logic typed,
                                  input fail_code_t code);
    directed_rows.push_back({ch, lst, typed, code});
  endfunction

  function automatic logic [7:0] pick_separator();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: b = ".";
      1: b = "-";
      2: b = "/";
      3: b = " ";
      default: begin
        b = 8'($urandom_range(0, 255));
        while (b >= ASCII_ZERO && b <= ASCII_NINE) b = 8'($urandom_range(0, 255));
      end
    endcase
    return b;
  endfunction

  // Offer one word, idling first at random; predict once it is taken
  task automatic offer_word(input logic [7:0] ch, input logic lst, input logic typed,
                            input fail_code_t code);
    verdict_t v;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= ch;
    in_last_char <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (predict_byte(ch, lst, v)) begin
      if (typed) begin
        v.code = code;
        v.ok   = (code == FAIL_NONE);
      end
      pending_verdicts.push_back(v);
    end
  endtask

  task automatic send_span(input int from, input int upto);
    int i;
    for (i = from; i < upto; i++)
      offer_word(text_q[i], i == text_q.size() - 1, 1'b0, FAIL_NONE);
  endtask

  // Stop offering, wait out every owed verdict and the pipeline tail
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    mode_now = m;
  endtask

  // Build one text: mostly right-length IDs, some wrong-length, some raw noise
  task automatic compose_text();
    int unsigned pick;
    int unsigned len;
    int unsigned need;
    int unsigned i;
    int unsigned s1;
    int unsigned s2;
    int unsigned same_d;
    bit          same;
    int unsigned digs[$];
    text_q.delete();
    need = (mode_now == MODE_CPF) ? CPF_LEN : CNPJ_LEN;
    pick = $urandom_range(99);
    if (pick >= 80) begin
      len = $urandom_range(1, 20);
      for (i = 0; i < len; i++) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    same_d = $urandom_range(0, 9);
    if (pick < 60) begin
      len  = need;
      pick = $urandom_range(99);
      same = (pick < 10);
    end else begin
      len = $urandom_range(0, 18);
      if (len == need) len++;
      same = ($urandom_range(99) < 30);
      pick = 99;
    end
    for (i = 0; i < len; i++) digs.push_back(same ? same_d : $urandom_range(0, 9));
    // Fill in correct check digits for most well-formed IDs
    if (!same && pick < 65) begin
      s1 = 0;
      for (i = 0; i < need - 2; i++) s1 += digs[i] * position_weight(mode_now, SUM_FIRST, 4'(i));
      digs[need - 2] = check_of(10'(s1));
      s2 = 0;
      for (i = 0; i < need - 1; i++) s2 += digs[i] * position_weight(mode_now, SUM_SECOND, 4'(i));
      digs[need - 1] = check_of(10'(s2));
    end
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 12) text_q.push_back(pick_separator());
      text_q.push_back(ASCII_ZERO + 8'(digs[i]));
    end
    if (text_q.size() == 0 || $urandom_range(99) < 20) text_q.push_back(pick_separator());
  endtask

  // Result side: check each taken verdict, then pick next ready
  int holds_served = 0;
  int hold_left = 0;

  always @(posedge clk) begin : rx_side
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict is_valid=%0b fail_code=%0d", $time, out_is_valid,
                 out_fail_code);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_is_valid !== want.ok) begin
          $display("%0t: is_valid expected %0b actual %0b", $time, want.ok, out_is_valid);
          mismatches++;
        end
        if (out_fail_code !== want.code) begin
          $display("%0t: fail_code expected %0d actual %0d", $time, want.code, out_fail_code);
          mismatches++;
        end
      end
    end
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int ph;
    int cut;
    int i;
    int phase_start;
    int waited;
    stim_row_t r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(MODE_CPF);

    // Empty texts at both byte extremes, digit range edges, then a known-good CPF
    add_row(8'h00, 1'b1, 1'b1, FAIL_COUNT);
    add_row(8'hFF, 1'b1, 1'b1, FAIL_COUNT);
    add_row("/", 1'b0, 1'b0, FAIL_NONE);
    add_row(":", 1'b0, 1'b0, FAIL_NONE);
    add_row("0", 1'b1, 1'b1, FAIL_COUNT);
    add_row("5", 1'b0, 1'b0, FAIL_NONE);
    add_row("2", 1'b0, 1'b0, FAIL_NONE);
    add_row("9", 1'b0, 1'b0, FAIL_NONE);
    add_row(".", 1'b0, 1'b0, FAIL_NONE);
    add_row("9", 1'b0, 1'b0, FAIL_NONE);
    add_row("8", 1'b0, 1'b0, FAIL_NONE);
    add_row("2", 1'b0, 1'b0, FAIL_NONE);
    add_row(".", 1'b0, 1'b0, FAIL_NONE);
    add_row("2", 1'b0, 1'b0, FAIL_NONE);
    add_row("4", 1'b0, 1'b0, FAIL_NONE);
    add_row("7", 1'b0, 1'b0, FAIL_NONE);
    add_row("-", 1'b0, 1'b0, FAIL_NONE);
    add_row("2", 1'b0, 1'b0, FAIL_NONE);
    add_row("5", 1'b1, 1'b1, FAIL_NONE);
    for (i = 0; i < directed_rows.size(); i++) begin
      r = directed_rows[i];
      offer_word(r.ch, r.lst, r.typed, r.code);
    end
    settle();

    // Random phases; from the second on, a text straddles the mode write
    cut = 0;
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        compose_text();
        cut = text_q.size() / 2;
        send_span(0, cut);
      end
      settle();
      if (ph == PHASES - 1) write_mode(logic'($urandom_range(0, 1)));
      else write_mode((ph % 2 == 0) ? MODE_CNPJ : MODE_CPF);
      if (ph == 1) hold_requests++;
      calm = (ph == 3);
      if (ph > 0) send_span(cut, text_q.size());
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        compose_text();
        send_span(0, text_q.size());
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending_verdicts.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_SLACK) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, pending_verdicts.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
